### design/gpm_pkg.sv
// gpm_pkg: shared types, register indexes and constants for the GF(2^8) polynomial MAC
// holds the controller state type, datapath command/status structs and the field multiply
// no dependencies
package gpm_pkg;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PAD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic absorb;
      logic pad;
      logic emit;
   } dp_cmd_type;

   typedef struct packed {
      logic cnt_zero;
      logic cnt_full;
      logic inc_full;
      logic last_key;
   } dp_sts_type;

   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_BLOCK_LEN = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY_COUNT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_KEY0      = 3'd2;
   localparam int NUM_KEY_REGS = 4;

   localparam logic [7:0] BLOCK_LEN_RESET = 8'd16;
   localparam logic [2:0] KEY_COUNT_RESET = 3'd1;

   localparam logic OP_DATA  = 1'b0;
   localparam logic OP_FLUSH = 1'b1;

   localparam logic [8:0] GF_POLY  = 9'h11B;
   localparam logic [7:0] PAD_BYTE = 8'h0A;

   function automatic logic [7:0] key_reset_value(input int k);
      logic [7:0] v;
      case (k)
         0: v = 8'd2;
         1: v = 8'd3;
         2: v = 8'd5;
         3: v = 8'd7;
         default: v = 8'd0;
      endcase
      return v;
   endfunction

   // shift-and-add multiply, reduced by the field polynomial at each step
   function automatic logic [7:0] gf_mul(input logic [7:0] a, input logic [7:0] b);
      logic [8:0] x;
      logic [7:0] prod;
      x    = {1'b0, a};
      prod = '0;
      for (int i = 0; i < 8; i++) begin
         if (b[i]) prod = prod ^ x[7:0];
         x = {x[7:0], 1'b0};
         if (x[8]) x = x ^ GF_POLY;
      end
      return prod;
   endfunction

endpackage

### design/gf256_polynomial_mac.sv
// gf256_polynomial_mac: per-key polynomial-evaluation MAC over GF(2^8), polynomial 0x11B
// a data byte is absorbed while idle; a flush pads a partial block with PAD_BYTE up to block_len
// after the byte or flush ending a block, results leave one per cycle unless rsp_stall holds,
// one per active key, during which no item is taken; bound by the single result register
// reset (synchronous, active high) clears counts and accumulators and restores register defaults
// depends on gpm_pkg, gpm_ctrl, gpm_datapath
module gf256_polynomial_mac #(
   parameter int MAX_KEYS = 4
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic                          req_opcode,
   input  logic [7:0]                    req_data_byte,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [7:0]                    rsp_mac_value,
   output logic [1:0]                    rsp_key_index,
   output logic                          rsp_last_of_block,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [gpm_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [7:0]                    csr_data
);
   import gpm_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   logic       csr_we;

   assign csr_we = csr_valid && csr_ready;

   gpm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_opcode (req_opcode),
      .req_stall  (req_stall),
      .rsp_valid  (rsp_valid),
      .rsp_stall  (rsp_stall),
      .csr_ready  (csr_ready),
      .sts        (sts),
      .cmd        (cmd)
   );

   gpm_datapath #(
      .MAX_KEYS (MAX_KEYS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .sts               (sts),
      .req_data_byte     (req_data_byte),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_mac_value     (rsp_mac_value),
      .rsp_key_index     (rsp_key_index),
      .rsp_last_of_block (rsp_last_of_block)
   );

endmodule

### design/gpm_ctrl.sv
// gpm_ctrl: controller for the GF(2^8) polynomial MAC
// sequences byte intake, flush padding and per-key result emission
// depends on gpm_pkg
module gpm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_opcode,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  csr_ready,
   input  gpm_pkg::dp_sts_type   sts,
   output gpm_pkg::dp_cmd_type   cmd
);
   import gpm_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_opcode == OP_DATA) begin
                  if (sts.inc_full) state_in = ST_EMIT;
               end else if (!sts.cnt_zero) begin
                  // a block already at length after a shorter block_len needs no padding
                  state_in = sts.cnt_full ? ST_EMIT : ST_PAD;
               end
            end
         end
         ST_PAD: begin
            if (sts.inc_full) state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (out_free && sts.last_key) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      cmd          = '0;
      req_stall    = 1'b1;
      csr_ready    = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      case (state_ff)
         ST_IDLE: begin
            req_stall  = 1'b0;
            csr_ready  = 1'b1;
            cmd.absorb = req_valid && (req_opcode == OP_DATA);
         end
         ST_PAD: begin
            cmd.absorb = 1'b1;
            cmd.pad    = 1'b1;
         end
         ST_EMIT: begin
            cmd.emit = out_free;
            if (out_free) rsp_valid_in = 1'b1;
         end
         default: begin
            cmd = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // padding only ever runs on a partial block
   a_pad_has_bytes: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_PAD) |-> !sts.cnt_zero)
      else $error("padding with an empty block");

   // emitting the last key returns to intake
   a_last_to_idle: assert property (@(posedge clock) disable iff (reset)
      (cmd.emit && sts.last_key) |=> (state_ff == ST_IDLE))
      else $error("controller did not leave emission after last key");

   // a held result is never dropped or overwritten
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_stall) |-> !cmd.emit)
      else $error("result register loaded while stalled");

endmodule

### design/gpm_datapath.sv
// gpm_datapath: registers, per-key GF(2^8) multipliers and result register for the MAC
// holds configuration, accumulators, running powers, byte count and emission index
// depends on gpm_pkg
module gpm_datapath #(
   parameter int MAX_KEYS = 4
) (
   input  logic                             clock,
   input  logic                             reset,
   input  gpm_pkg::dp_cmd_type              cmd,
   output gpm_pkg::dp_sts_type              sts,
   input  logic [7:0]                       req_data_byte,
   input  logic                             csr_we,
   input  logic [gpm_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [7:0]                       csr_data,
   output logic [7:0]                       rsp_mac_value,
   output logic [1:0]                       rsp_key_index,
   output logic                             rsp_last_of_block
);
   import gpm_pkg::*;

   localparam int KW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

   logic [7:0]    keys_ff [MAX_KEYS];
   logic [7:0]    keys_in [MAX_KEYS];
   logic [7:0]    acc_ff  [MAX_KEYS];
   logic [7:0]    acc_in  [MAX_KEYS];
   logic [7:0]    pow_ff  [MAX_KEYS];
   logic [7:0]    pow_in  [MAX_KEYS];
   logic [7:0]    block_len_ff;
   logic [7:0]    block_len_in;
   logic [2:0]    key_count_ff;
   logic [2:0]    key_count_in;
   logic [7:0]    cnt_ff;
   logic [7:0]    cnt_in;
   logic [KW-1:0] idx_ff;
   logic [KW-1:0] idx_in;
   logic [7:0]    mac_ff;
   logic [1:0]    kidx_ff;
   logic          last_ff;

   logic [7:0]    feed;
   logic [7:0]    cnt_inc;
   logic [7:0]    eff_len;
   logic [2:0]    kc_m1;
   logic [KW-1:0] last_idx;
   logic          block_done;

   assign feed       = cmd.pad ? PAD_BYTE : req_data_byte;
   assign cnt_inc    = (cnt_ff == 8'hFF) ? cnt_ff : cnt_ff + 8'd1;
   assign eff_len    = (block_len_ff == 8'd0) ? 8'd1 : block_len_ff;
   assign kc_m1      = (key_count_ff == 3'd0) ? 3'd0 : key_count_ff - 3'd1;
   assign last_idx   = (kc_m1 > 3'(MAX_KEYS - 1)) ? KW'(MAX_KEYS - 1) : KW'(kc_m1);
   assign block_done = cmd.emit && sts.last_key;

   assign sts.cnt_zero = (cnt_ff == 8'd0);
   assign sts.cnt_full = (cnt_ff >= eff_len);
   assign sts.inc_full = (cnt_inc >= eff_len);
   assign sts.last_key = (idx_ff == last_idx);

   always_comb begin
      block_len_in = block_len_ff;
      key_count_in = key_count_ff;
      if (csr_we && csr_index == CSR_BLOCK_LEN) block_len_in = csr_data;
      if (csr_we && csr_index == CSR_KEY_COUNT) key_count_in = csr_data[2:0];
      for (int k = 0; k < MAX_KEYS; k++) begin
         keys_in[k] = keys_ff[k];
         acc_in[k]  = acc_ff[k];
         pow_in[k]  = pow_ff[k];
         if (cmd.absorb) begin
            acc_in[k] = acc_ff[k] ^ gf_mul(feed, pow_ff[k]);
            pow_in[k] = gf_mul(pow_ff[k], keys_ff[k]);
         end
         if (block_done) begin
            acc_in[k] = 8'd0;
            pow_in[k] = keys_ff[k];
         end
         if (csr_we && (k < NUM_KEY_REGS) && (csr_index == CSR_IDX_W'(CSR_KEY0 + k))) begin
            keys_in[k] = csr_data;
            // mid-block the running power carries on with the new key
            if (cnt_ff == 8'd0) pow_in[k] = csr_data;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      idx_in = idx_ff;
      if (cmd.absorb) cnt_in = cnt_inc;
      if (block_done) begin
         cnt_in = 8'd0;
         idx_in = '0;
      end else if (cmd.emit) begin
         idx_in = idx_ff + KW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         block_len_ff <= BLOCK_LEN_RESET;
         key_count_ff <= KEY_COUNT_RESET;
         cnt_ff       <= 8'd0;
         idx_ff       <= '0;
         for (int k = 0; k < MAX_KEYS; k++) begin
            keys_ff[k] <= key_reset_value(k);
            acc_ff[k]  <= 8'd0;
            pow_ff[k]  <= key_reset_value(k);
         end
      end else begin
         block_len_ff <= block_len_in;
         key_count_ff <= key_count_in;
         cnt_ff       <= cnt_in;
         idx_ff       <= idx_in;
         for (int k = 0; k < MAX_KEYS; k++) begin
            keys_ff[k] <= keys_in[k];
            acc_ff[k]  <= acc_in[k];
            pow_ff[k]  <= pow_in[k];
         end
      end
   end

   // result register, loaded only when the output side can take it
   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         mac_ff  <= acc_ff[idx_ff];
         kidx_ff <= 2'(idx_ff);
         last_ff <= sts.last_key;
      end
   end

   assign rsp_mac_value     = mac_ff;
   assign rsp_key_index     = kidx_ff;
   assign rsp_last_of_block = last_ff;

   a_block_restart: assert property (@(posedge clock) disable iff (reset)
      block_done |=> (cnt_ff == 8'd0 && idx_ff == '0))
      else $error("block state not cleared after last result");

   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> (idx_ff <= last_idx))
      else $error("emission index past last active key");

endmodule
